/* rtl/set_assoc_cache_tag_controller_macros.svh */
// Assertion macros shared by the checker of the cache tag controller.
// Depends on nothing; included by the checker file.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH

// Condition a implies condition c at the same clock edge.
`define SACTC_ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("cache tag controller check failed");

// Condition a implies condition c at the next clock edge.
`define SACTC_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("cache tag controller check failed");

`endif

/* rtl/sactc_pkg.sv */
// Types, codes and helper functions of the cache tag controller.
// Depends on nothing; used by the top level and the checker.
package sactc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_OFFSET_BITS    = 3'd0,
    CFG_INDEX_BITS     = 3'd1,
    CFG_WAYS_IN_USE    = 3'd2,
    CFG_WRITE_POLICY   = 3'd3,
    CFG_REPLACE_POLICY = 3'd4,
    CFG_ACCESS_TIME    = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] REPL_LFU   = 2'd0;
  localparam logic [1:0] REPL_LRU   = 2'd1;
  localparam logic [1:0] REPL_RND   = 2'd2;
  localparam logic [1:0] REPL_WAY0  = 2'd3;

  localparam logic WP_THROUGH = 1'b0;
  localparam logic WP_BACK    = 1'b1;

  localparam logic OP_WRITE = 1'b1;

  localparam int unsigned WAY_IDX_W = 4;  // enough for up to 16 ways
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // One way of a set as kept in the set memory.
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [15:0] freq;
    logic [31:0] stamp;
    logic [31:0] tag;
  } way_entry_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] x, input logic en);
    logic [31:0] r;
    r = x;
    if (en && (x != 32'hFFFF_FFFF)) begin
      r = x + 32'd1;
    end
    return r;
  endfunction

endpackage

/* rtl/sactc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module sactc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/set_assoc_cache_tag_controller.sv */
// Top level of the set-associative cache tag and policy controller.
// Depends on sactc_pkg and sactc_ram.
//
// Usage: an access item (address_i, op_i) enters on in_valid_i/in_ready_o.
// The byte address is split into offset, set index and tag using the
// configured line size and set count. The whole set (all ways, with tag,
// valid, dirty, use frequency and last-use stamp) lives in one row of a
// synchronous RAM. The block reads that row at acceptance, compares the tags
// and picks a victim in the next cycle, and writes the updated row back when
// the item commits. One result item per access leaves on out_valid_o /
// out_ready_i, carrying hit, way, memory traffic flags, the echoed latency
// and the six saturating running totals.
// Each item passes a set read, then a compare and write back; a new item is
// taken only after the last one commits. A miss under random replacement
// first steps the LFSR and then forms the bit-serial remainder of the new
// value by the way count before it commits.
// A result waits in the output register; a stalled receiver holds the
// following item in its compare cycle until the register frees up.
// Reset clears the per-set valid flags, statistics and access clock and loads
// the LFSR seed at once; no clearing pass runs. Configuration writes are always
// accepted and must only be issued while the block is idle.
module set_assoc_cache_tag_controller
  import sactc_pkg::*;
#(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            address_i,
  input  logic                   op_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic [2:0]             way_used_o,
  output logic                   memory_read_o,
  output logic                   memory_write_o,
  output logic [15:0]            latency_o,
  output logic [31:0]            hits_total_o,
  output logic [31:0]            misses_total_o,
  output logic [31:0]            read_misses_total_o,
  output logic [31:0]            write_misses_total_o,
  output logic [31:0]            mem_reads_total_o,
  output logic [31:0]            mem_writes_total_o
);

  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned IB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned ROW_W  = MAX_WAYS * $bits(way_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOD
  } state_e;

  // Configuration registers.
  logic [3:0]  offset_bits_q, index_bits_q, ways_in_use_q;
  logic        write_policy_q;
  logic [1:0]  replace_policy_q;
  logic [15:0] access_time_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q    <= 4'd5;
      index_bits_q     <= 4'd6;
      ways_in_use_q    <= 4'd4;
      write_policy_q   <= WP_BACK;
      replace_policy_q <= REPL_LRU;
      access_time_q    <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_BITS:    offset_bits_q    <= cfg_data_i[3:0];
        CFG_INDEX_BITS:     index_bits_q     <= cfg_data_i[3:0];
        CFG_WAYS_IN_USE:    ways_in_use_q    <= cfg_data_i[3:0];
        CFG_WRITE_POLICY:   write_policy_q   <= cfg_data_i[0];
        CFG_REPLACE_POLICY: replace_policy_q <= cfg_data_i[1:0];
        CFG_ACCESS_TIME:    access_time_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: the set count is clamped to what the memory holds,
  // and the way count to the range one to MAX_WAYS.
  logic [3:0] ib_eff;
  logic [4:0] ways_eff;
  assign ib_eff = (index_bits_q > 4'(IB_MAX)) ? 4'(IB_MAX) : index_bits_q;

  always_comb begin
    if (ways_in_use_q == 4'd0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, ways_in_use_q} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_in_use_q};
    end
  end

  // Address split at acceptance.
  logic [31:0]      set_full, tag_in;
  logic [SET_W-1:0] set_idx;
  logic [4:0]       tag_shift;
  assign set_full  = (address_i >> offset_bits_q) & ((32'd1 << ib_eff) - 32'd1);
  assign set_idx   = set_full[SET_W-1:0];
  assign tag_shift = {1'b0, offset_bits_q} + {1'b0, ib_eff};
  assign tag_in    = address_i >> tag_shift;

  // Control and payload state.
  state_e           state_q;
  logic [SET_W-1:0] set_q;
  logic [31:0]      tag_q;
  logic             op_q;
  logic             rvld_q;
  logic [MAX_SETS-1:0] row_vld_q;
  logic [31:0]      clock_q;
  logic [15:0]      lfsr_q;
  logic [4:0]       rem_q;
  logic [3:0]       cnt_q;
  logic             rnd_done_q;
  logic [31:0]      stat_q [6];
  logic             out_valid_q;
  logic             hit_q, mrd_q, mwr_q;
  logic [2:0]       way_q;
  logic [15:0]      lat_q;

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Set memory.
  logic [ROW_W-1:0] rdata, wdata;
  logic             ram_we;

  sactc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (wdata),
    .re_i    (in_acc),
    .raddr_i (set_idx),
    .rdata_o (rdata)
  );

  // A set never written since reset reads as all zero.
  way_entry_t [MAX_WAYS-1:0] row, new_row;
  assign row = rvld_q ? rdata : '0;

  // Tag compare: the lowest valid matching way in use wins.
  logic                 hit;
  logic [WAY_IDX_W-1:0] hit_way;
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!hit && (5'(i) < ways_eff) && row[i].valid && (row[i].tag == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_IDX_W'(i);
      end
    end
  end

  // Least frequently and least recently used ways; ties keep the lower way.
  logic [WAY_IDX_W-1:0] lfu_way, lru_way;
  logic [15:0]          best_f;
  logic [31:0]          best_s;
  always_comb begin
    lfu_way = '0;
    lru_way = '0;
    best_f  = row[0].freq;
    best_s  = row[0].stamp;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if ((5'(i) < ways_eff) && (row[i].freq < best_f)) begin
        best_f  = row[i].freq;
        lfu_way = WAY_IDX_W'(i);
      end
      if ((5'(i) < ways_eff) && (row[i].stamp < best_s)) begin
        best_s  = row[i].stamp;
        lru_way = WAY_IDX_W'(i);
      end
    end
  end

  logic [WAY_IDX_W-1:0] victim, sel_way;
  always_comb begin
    unique case (replace_policy_q)
      REPL_LFU: victim = lfu_way;
      REPL_LRU: victim = lru_way;
      REPL_RND: victim = rem_q[WAY_IDX_W-1:0];
      default:  victim = '0;
    endcase
  end
  assign sel_way = hit ? hit_way : victim;

  way_entry_t vict_e;
  always_comb begin
    vict_e = row[0];
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_IDX_W'(i) == victim) begin
        vict_e = row[i];
      end
    end
  end

  logic [31:0] clock_nxt;
  logic        mrd, mwr;
  assign clock_nxt = clock_q + 32'd1;
  assign mrd = !hit && (op_q != OP_WRITE);
  assign mwr = !hit && (((op_q == OP_WRITE) && (write_policy_q == WP_THROUGH)) ||
                        (vict_e.valid && vict_e.dirty && (write_policy_q == WP_BACK)));

  // Updated set row.
  always_comb begin
    new_row = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_IDX_W'(i) == sel_way) begin
        if (hit) begin
          new_row[i].dirty = row[i].dirty | (op_q == OP_WRITE);
          new_row[i].freq  = (row[i].freq == 16'hFFFF) ? row[i].freq : row[i].freq + 16'd1;
          new_row[i].stamp = clock_nxt;
        end else begin
          new_row[i].valid = 1'b1;
          new_row[i].dirty = (op_q == OP_WRITE);
          new_row[i].freq  = 16'd1;
          new_row[i].stamp = clock_nxt;
          new_row[i].tag   = tag_q;
        end
      end
    end
  end
  assign wdata = new_row;

  // A random miss first needs the remainder of the stepped LFSR value.
  logic need_rnd, commit;
  assign need_rnd = !hit && (replace_policy_q == REPL_RND);
  assign commit   = (state_q == ST_LOOK) && (!need_rnd || rnd_done_q) &&
                    (!out_valid_q || out_ready_i);
  assign ram_we   = commit;

  logic [15:0] lfsr_nxt;
  assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  // One restoring remainder step per cycle, most significant bit first.
  logic [4:0] rem_sh, rem_nxt;
  assign rem_sh  = {rem_q[3:0], lfsr_q[4'd15 - cnt_q]};
  assign rem_nxt = (rem_sh >= ways_eff) ? rem_sh - ways_eff : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      set_q       <= '0;
      tag_q       <= '0;
      op_q        <= 1'b0;
      rvld_q      <= 1'b0;
      row_vld_q   <= '0;
      clock_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      rem_q       <= '0;
      cnt_q       <= '0;
      rnd_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      way_q       <= '0;
      mrd_q       <= 1'b0;
      mwr_q       <= 1'b0;
      lat_q       <= '0;
      for (int k = 0; k < 6; k++) begin
        stat_q[k] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            set_q   <= set_idx;
            tag_q   <= tag_in;
            op_q    <= op_i;
            rvld_q  <= row_vld_q[set_idx];
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (need_rnd && !rnd_done_q) begin
            lfsr_q  <= lfsr_nxt;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_MOD;
          end else if (commit) begin
            row_vld_q[set_q] <= 1'b1;
            clock_q     <= clock_nxt;
            rnd_done_q  <= 1'b0;
            out_valid_q <= 1'b1;
            hit_q       <= hit;
            way_q       <= sel_way[2:0];
            mrd_q       <= mrd;
            mwr_q       <= mwr;
            lat_q       <= access_time_q;
            stat_q[0]   <= sat_inc32(stat_q[0], hit);
            stat_q[1]   <= sat_inc32(stat_q[1], !hit);
            stat_q[2]   <= sat_inc32(stat_q[2], mrd);
            stat_q[3]   <= sat_inc32(stat_q[3], !hit && (op_q == OP_WRITE));
            stat_q[4]   <= sat_inc32(stat_q[4], mrd);
            stat_q[5]   <= sat_inc32(stat_q[5], mwr);
            state_q     <= ST_IDLE;
          end
        end
        ST_MOD: begin
          rem_q <= rem_nxt;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            rnd_done_q <= 1'b1;
            state_q    <= ST_LOOK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign hit_o                = hit_q;
  assign way_used_o           = way_q;
  assign memory_read_o        = mrd_q;
  assign memory_write_o       = mwr_q;
  assign latency_o            = lat_q;
  assign hits_total_o         = stat_q[0];
  assign misses_total_o       = stat_q[1];
  assign read_misses_total_o  = stat_q[2];
  assign write_misses_total_o = stat_q[3];
  assign mem_reads_total_o    = stat_q[4];
  assign mem_writes_total_o   = stat_q[5];

endmodule

/* rtl/sactc_checker.sv */
// Port-level checker of the cache tag controller and its bind statement.
// Depends on sactc_pkg and set_assoc_cache_tag_controller_macros.svh.
`include "set_assoc_cache_tag_controller_macros.svh"

module sactc_checker
  import sactc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic hit_o,
  input logic memory_read_o,
  input logic memory_write_o
);

  `SACTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `SACTC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SACTC_ASSERT_SAME(a_read_only_on_miss, clk_i, rst_ni, out_valid_o && memory_read_o, !hit_o)
  `SACTC_ASSERT_SAME(a_write_only_on_miss, clk_i, rst_ni, out_valid_o && hit_o, !memory_write_o)

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_sactc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .hit_o          (hit_o),
  .memory_read_o  (memory_read_o),
  .memory_write_o (memory_write_o)
);
